// ----- rtl/erm_pkg.sv -----
// ----------------------------------------------------------------------------
// erm_pkg
// shared constants, cordic arctangent table and cordic stage type
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int unsigned AngleWidthDef    = 16;
  localparam int unsigned EntryFracBitsDef = 14;
  localparam int unsigned FieldWidth       = 16;
  localparam int unsigned CordicSteps      = 20;
  localparam int unsigned CordicWidth      = 34;
  localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;

  function automatic logic signed [CordicWidth-1:0] atan_turn(input logic [4:0] idx);
    logic signed [CordicWidth-1:0] v;
    case (idx)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679838;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2608;
      5'd19:   v = 34'sd1304;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [CordicWidth-1:0] x;
    logic signed [CordicWidth-1:0] y;
    logic signed [CordicWidth-1:0] z;
    logic [1:0]                    q;
  } cordic_t;

endpackage

// ----- rtl/erm_if.sv -----
// ----------------------------------------------------------------------------
// erm_if
// valid/ready channel carrying one item of a generic payload type
// ----------------------------------------------------------------------------
interface erm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/erm_sincos.sv -----
// ----------------------------------------------------------------------------
// erm_sincos
// pipelined cordic, one iteration per stage, cos/sin in q1.F out
// ----------------------------------------------------------------------------
module erm_sincos #(
  parameter int unsigned ANGLE_WIDTH     = erm_pkg::AngleWidthDef,
  parameter int unsigned ENTRY_FRAC_BITS = erm_pkg::EntryFracBitsDef
) (
  input  logic                                clk_i,
  input  logic [erm_pkg::CordicSteps+1:0]     en_i,
  input  logic [ANGLE_WIDTH-1:0]              angle_i,
  output logic signed [ENTRY_FRAC_BITS+1:0]   cos_o,
  output logic signed [ENTRY_FRAC_BITS+1:0]   sin_o
);
  localparam int unsigned N  = erm_pkg::CordicSteps;
  localparam int unsigned W  = erm_pkg::CordicWidth;
  localparam int unsigned F  = ENTRY_FRAC_BITS;
  localparam int unsigned Sh = 30 - F;
  localparam logic signed [W-1:0] Half = W'(64'sd1 <<< (Sh - 1));
  localparam logic signed [W-1:0] One  = W'(64'sd1 <<< F);

  erm_pkg::cordic_t stg_q [N+1];
  logic [31:0] a;
  logic [1:0]  q;
  logic [31:0] resu;

  always_comb begin
    a    = 32'(angle_i) << (32 - ANGLE_WIDTH);
    q    = 2'((a + 32'h2000_0000) >> 30);
    resu = a - {q, 30'd0};
  end

  // stage 0: quadrant reduction
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      stg_q[0].x <= erm_pkg::CordicGain;
      stg_q[0].y <= '0;
      stg_q[0].z <= W'(signed'(resu));
      stg_q[0].q <= q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        stg_q[i+1].q <= stg_q[i].q;
        if (!stg_q[i].z[W-1]) begin
          stg_q[i+1].x <= stg_q[i].x - (stg_q[i].y >>> i);
          stg_q[i+1].y <= stg_q[i].y + (stg_q[i].x >>> i);
          stg_q[i+1].z <= stg_q[i].z - erm_pkg::atan_turn(5'(i));
        end else begin
          stg_q[i+1].x <= stg_q[i].x + (stg_q[i].y >>> i);
          stg_q[i+1].y <= stg_q[i].y - (stg_q[i].x >>> i);
          stg_q[i+1].z <= stg_q[i].z + erm_pkg::atan_turn(5'(i));
        end
      end
    end
  end

  logic signed [W-1:0] cr, sr, cc, sc;
  always_comb begin
    cr = (stg_q[N].x + Half) >>> Sh;
    sr = (stg_q[N].y + Half) >>> Sh;
    cc = (cr > One) ? One : ((cr < -One) ? -One : cr);
    sc = (sr > One) ? One : ((sr < -One) ? -One : sr);
  end

  // final stage: round, clamp, quadrant map
  always_ff @(posedge clk_i) begin
    if (en_i[N+1]) begin
      case (stg_q[N].q)
        2'd0:    begin cos_o <= (F+2)'(cc);  sin_o <= (F+2)'(sc);  end
        2'd1:    begin cos_o <= (F+2)'(-sc); sin_o <= (F+2)'(cc);  end
        2'd2:    begin cos_o <= (F+2)'(-cc); sin_o <= (F+2)'(-sc); end
        default: begin cos_o <= (F+2)'(sc);  sin_o <= (F+2)'(-cc); end
      endcase
    end
  end
endmodule

// ----- rtl/euler_rotation_matrix.sv -----
// pipeline: cordic lanes, then product stage a, product stage b, sum stage, output register
// throughput: one item per cycle unless the output stalls; pipeline advances whenever the output
// register is free or being taken, so a stall holds every stage in place
// reset: rst_ni clears all valid bits asynchronously; data needs no reset
// ----------------------------------------------------------------------------
// euler_rotation_matrix
// angles about x, y, z to the nine entries of rz*ry*rx in signed q1.F
// ----------------------------------------------------------------------------
module euler_rotation_matrix #(
  parameter int unsigned ANGLE_WIDTH     = erm_pkg::AngleWidthDef,
  parameter int unsigned ENTRY_FRAC_BITS = erm_pkg::EntryFracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  erm_if.sink   in_if,
  erm_if.source out_if
);
  localparam int unsigned F    = ENTRY_FRAC_BITS;
  localparam int unsigned EW   = F + 2;           // entry width, holds +-2^F
  localparam int unsigned PW   = 2 * EW;          // product width
  localparam int unsigned FW   = erm_pkg::FieldWidth;
  localparam int unsigned NC   = erm_pkg::CordicSteps + 2;
  localparam int unsigned NS   = NC + 4;          // total stages
  localparam logic signed [EW-1:0] One = EW'(64'sd1 <<< F);

  typedef logic signed [EW-1:0] ent_t;

  // valid chain and global enable: stages hold when the tail is stuck
  logic [NS-1:0] vld_q;
  logic          adv;
  assign adv          = !out_if.valid || out_if.ready;
  assign in_if.ready  = adv;
  assign out_if.valid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_if.valid};
    end
  end

  logic [NC-1:0] en;
  always_comb begin
    en[0] = adv && in_if.valid;
    for (int k = 1; k < NC; k++) en[k] = adv && vld_q[k-1];
  end

  // three cordic lanes in lockstep
  ent_t cx, sx, cy, sy, cz, sz;
  erm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .ENTRY_FRAC_BITS(F)) u_sc_x (
    .clk_i, .en_i(en), .angle_i(ANGLE_WIDTH'(in_if.data.angle_x)), .cos_o(cx), .sin_o(sx));
  erm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .ENTRY_FRAC_BITS(F)) u_sc_y (
    .clk_i, .en_i(en), .angle_i(ANGLE_WIDTH'(in_if.data.angle_y)), .cos_o(cy), .sin_o(sy));
  erm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .ENTRY_FRAC_BITS(F)) u_sc_z (
    .clk_i, .en_i(en), .angle_i(ANGLE_WIDTH'(in_if.data.angle_z)), .cos_o(cz), .sin_o(sz));

  // rounded fixed-point product, floor((a*b + half) >> F)
  function automatic ent_t fmul(input ent_t a, input ent_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + PW'(64'sd1 <<< (F - 1));
    return EW'(p >>> F);
  endfunction

  function automatic ent_t clamp(input logic signed [EW:0] v);
    if (v > (EW+1)'(One))  return One;
    if (v < -(EW+1)'(One)) return -One;
    return EW'(v);
  endfunction

  // product stage a: first-level products plus delayed trig terms
  ent_t czsy_q, szsy_q, czcy_q, szcy_q, cysx_q, cycx_q, sy_a_q;
  ent_t szcx_q, szsx_q, czcx_q, czsx_q, cx_a_q, sx_a_q;
  always_ff @(posedge clk_i) begin
    if (adv && vld_q[NC-1]) begin
      czsy_q <= fmul(cz, sy);
      szsy_q <= fmul(sz, sy);
      czcy_q <= fmul(cz, cy);
      szcy_q <= fmul(sz, cy);
      cysx_q <= fmul(cy, sx);
      cycx_q <= fmul(cy, cx);
      szcx_q <= fmul(sz, cx);
      szsx_q <= fmul(sz, sx);
      czcx_q <= fmul(cz, cx);
      czsx_q <= fmul(cz, sx);
      sy_a_q <= sy;
      cx_a_q <= cx;
      sx_a_q <= sx;
    end
  end

  // product stage b: triple products plus delayed first-level terms
  ent_t t1_q, t2_q, t4_q, t5_q;
  ent_t b0_q, b1_q, b2_q, b3_q, b4_q, b5_q, b6_q, b7_q, b8_q;
  always_ff @(posedge clk_i) begin
    if (adv && vld_q[NC]) begin
      t1_q <= fmul(czsy_q, sx_a_q);
      t2_q <= fmul(czsy_q, cx_a_q);
      t4_q <= fmul(szsy_q, sx_a_q);
      t5_q <= fmul(szsy_q, cx_a_q);
      b0_q <= czcy_q;
      b1_q <= szcx_q;
      b2_q <= szsx_q;
      b3_q <= szcy_q;
      b4_q <= czcx_q;
      b5_q <= czsx_q;
      b6_q <= sy_a_q;
      b7_q <= cysx_q;
      b8_q <= cycx_q;
    end
  end

  // sum stage: combine and clamp
  ent_t r_q [9];
  always_ff @(posedge clk_i) begin
    if (adv && vld_q[NC+1]) begin
      r_q[0] <= clamp((EW+1)'(b0_q));
      r_q[1] <= clamp((EW+1)'(b1_q) - (EW+1)'(t1_q));
      r_q[2] <= clamp((EW+1)'(b2_q) + (EW+1)'(t2_q));
      r_q[3] <= clamp(-(EW+1)'(b3_q));
      r_q[4] <= clamp((EW+1)'(b4_q) + (EW+1)'(t4_q));
      r_q[5] <= clamp((EW+1)'(b5_q) - (EW+1)'(t5_q));
      r_q[6] <= clamp(-(EW+1)'(b6_q));
      r_q[7] <= clamp(-(EW+1)'(b7_q));
      r_q[8] <= clamp((EW+1)'(b8_q));
    end
  end

  // output register, fields truncated or sign-extended to 16 bits
  ent_t o_q [9];
  always_ff @(posedge clk_i) begin
    if (adv && vld_q[NC+2]) begin
      for (int k = 0; k < 9; k++) o_q[k] <= r_q[k];
    end
  end

  assign out_if.data.row1_col1 = FW'(o_q[0]);
  assign out_if.data.row1_col2 = FW'(o_q[1]);
  assign out_if.data.row1_col3 = FW'(o_q[2]);
  assign out_if.data.row2_col1 = FW'(o_q[3]);
  assign out_if.data.row2_col2 = FW'(o_q[4]);
  assign out_if.data.row2_col3 = FW'(o_q[5]);
  assign out_if.data.row3_col1 = FW'(o_q[6]);
  assign out_if.data.row3_col2 = FW'(o_q[7]);
  assign out_if.data.row3_col3 = FW'(o_q[8]);

  // a stalled output must keep its valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid)
    else $error("result item dropped under stall");

  // accepted item appears in the pipe in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> vld_q[0])
    else $error("accepted item lost at pipe entry");

  // pipeline holds completely while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid chain moved during stall");
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// streams angle items into euler_rotation_matrix and compares every matrix
// item field by field against an in-bench fixed-point cordic model
// ----------------------------------------------------------------------------
module testbench;

  // channel payloads, laid out as the block reads them
  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] row1_col1;
    logic signed [15:0] row1_col2;
    logic signed [15:0] row1_col3;
    logic signed [15:0] row2_col1;
    logic signed [15:0] row2_col2;
    logic signed [15:0] row2_col3;
    logic signed [15:0] row3_col1;
    logic signed [15:0] row3_col2;
    logic signed [15:0] row3_col3;
  } matrix_t;

  localparam int FracBits  = 14;
  localparam int Steps     = 20;
  localparam int Latency   = 26;
  localparam int IdleLimit = 4000;
  localparam longint Gain  = 652032874;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam longint AtanTab [Steps] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304
  };

  logic clk_i;
  logic rst_ni;

  erm_if #(.payload_t(angles_t)) in_ch  ();
  erm_if #(.payload_t(matrix_t)) out_ch ();

  euler_rotation_matrix i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  matrix_t pending_matrices[$];
  int      error_count;
  int      sent_count;
  int      checked_count;
  int      idle_cycles;
  bit      no_gaps;     // when set, neither side idles
  int      stall_left;
  int      sink_wait;

  // clock; the single reset at the start is driven from the main initial block
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // round half up then floor shift, as the datapath narrows
  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_one(longint v);
    longint one;
    one = longint'(1) <<< FracBits;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shr(a * b, FracBits);
  endfunction

  // nearest-quadrant reduction followed by the rotation-mode cordic
  task automatic trig(input logic [15:0] ang, output longint c_o, output longint s_o);
    logic [31:0] turn32;
    logic [1:0]  quad;
    logic [31:0] resid;
    longint      x, y, z, dx, dy, c, s;
    turn32 = {ang, 16'h0000};
    quad   = 2'((turn32 + 32'h2000_0000) >> 30);
    resid  = turn32 - {quad, 30'd0};
    z = longint'($signed(resid));
    x = Gain;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= AtanTab[i];
      end else begin
        x += dx;
        y -= dy;
        z += AtanTab[i];
      end
    end
    c = clamp_one(round_shr(x, 30 - FracBits));
    s = clamp_one(round_shr(y, 30 - FracBits));
    case (quad)
      2'd0: begin c_o = c;  s_o = s;  end
      2'd1: begin c_o = -s; s_o = c;  end
      2'd2: begin c_o = -c; s_o = -s; end
      default: begin c_o = s; s_o = -c; end
    endcase
  endtask

  // entries of rz * ry * rx, each clamped to +-1.0
  task automatic rotation_of(input angles_t a, output matrix_t m);
    longint cx, sx, cy, sy, cz, sz, czsy, szsy;
    trig(a.angle_x, cx, sx);
    trig(a.angle_y, cy, sy);
    trig(a.angle_z, cz, sz);
    czsy = qmul(cz, sy);
    szsy = qmul(sz, sy);
    m.row1_col1 = 16'(clamp_one(qmul(cz, cy)));
    m.row1_col2 = 16'(clamp_one(qmul(sz, cx) - qmul(czsy, sx)));
    m.row1_col3 = 16'(clamp_one(qmul(sz, sx) + qmul(czsy, cx)));
    m.row2_col1 = 16'(clamp_one(-qmul(sz, cy)));
    m.row2_col2 = 16'(clamp_one(qmul(cz, cx) + qmul(szsy, sx)));
    m.row2_col3 = 16'(clamp_one(qmul(cz, sx) - qmul(szsy, cx)));
    m.row3_col1 = 16'(clamp_one(-sy));
    m.row3_col2 = 16'(clamp_one(-qmul(cy, sx)));
    m.row3_col3 = 16'(clamp_one(qmul(cy, cx)));
  endtask

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // send one angle item after a random gap; valid stays up for back-to-back
  task automatic send_angles(input angles_t a);
    int      gap;
    matrix_t m;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= a;
    do @(posedge clk_i); while (!in_ch.ready);
    rotation_of(a, m);
    pending_matrices.push_back(m);
    sent_count++;
  endtask

  task automatic send_xyz(input int ax, input int ay, input int az);
    angles_t a;
    a.angle_x = 16'(ax);
    a.angle_y = 16'(ay);
    a.angle_z = 16'(az);
    send_angles(a);
  endtask

  // sink side: after each taken item draw a random wait length, unless no_gaps is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (no_gaps) begin
        out_ch.ready <= 1'b1;
      end else begin
        sink_wait    = $urandom_range(0, 18);
        stall_left   <= (sink_wait > 0) ? sink_wait - 1 : 0;
        out_ch.ready <= (sink_wait == 0);
      end
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    matrix_t want;
    matrix_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_matrices.size() == 0) begin
        $error("matrix item with nothing expected: %h", got);
        error_count++;
      end else begin
        want = pending_matrices.pop_front();
        checked_count++;
        if (got.row1_col1 !== want.row1_col1) begin
          $error("row1_col1 expected %0d actual %0d", want.row1_col1, got.row1_col1);
          error_count++;
        end
        if (got.row1_col2 !== want.row1_col2) begin
          $error("row1_col2 expected %0d actual %0d", want.row1_col2, got.row1_col2);
          error_count++;
        end
        if (got.row1_col3 !== want.row1_col3) begin
          $error("row1_col3 expected %0d actual %0d", want.row1_col3, got.row1_col3);
          error_count++;
        end
        if (got.row2_col1 !== want.row2_col1) begin
          $error("row2_col1 expected %0d actual %0d", want.row2_col1, got.row2_col1);
          error_count++;
        end
        if (got.row2_col2 !== want.row2_col2) begin
          $error("row2_col2 expected %0d actual %0d", want.row2_col2, got.row2_col2);
          error_count++;
        end
        if (got.row2_col3 !== want.row2_col3) begin
          $error("row2_col3 expected %0d actual %0d", want.row2_col3, got.row2_col3);
          error_count++;
        end
        if (got.row3_col1 !== want.row3_col1) begin
          $error("row3_col1 expected %0d actual %0d", want.row3_col1, got.row3_col1);
          error_count++;
        end
        if (got.row3_col2 !== want.row3_col2) begin
          $error("row3_col2 expected %0d actual %0d", want.row3_col2, got.row3_col2);
          error_count++;
        end
        if (got.row3_col3 !== want.row3_col3) begin
          $error("row3_col3 expected %0d actual %0d", want.row3_col3, got.row3_col3);
          error_count++;
        end
      end
    end
  end

  // watchdog: cycles in which neither channel moves an item
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d matrix items outstanding",
               pending_matrices.size());
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // identity, field extremes, quadrant edges, single-axis and planar cases
  task automatic test_directed();
    send_xyz(0, 0, 0);                          // zero angles give exact 1.0 / 0.0
    send_xyz(16'h7fff, 16'h7fff, 16'h7fff);
    send_xyz(16'h8000, 16'h8000, 16'h8000);     // half turn on each axis
    send_xyz(16'hffff, 1, 16'hffff);
    send_xyz(16'h4000, 0, 0);                   // quarter turns, one axis at a time
    send_xyz(0, 16'h4000, 0);
    send_xyz(0, 0, 16'h4000);
    send_xyz(16'hc000, 16'hc000, 16'hc000);
    send_xyz(16'h2000, 16'h1fff, 16'h6000);     // nearest-quadrant tie points
    send_xyz(16'ha000, 16'he000, 16'hdfff);
    send_xyz(16'h1555, 0, 0);                   // pure x
    send_xyz(0, 16'hd555, 0);                   // pure y
    send_xyz(0, 0, 16'h0800);                   // planar rotation about z
    send_xyz(0, 0, 16'hf800);
    send_xyz(16'h5555, 16'haaaa, 16'h3333);
    send_xyz(16'h0001, 16'h8001, 16'h7ffe);
  endtask

  // random poses: full range, small angles, single axis, near quadrant edges
  task automatic test_random(input int count);
    angles_t a;
    for (int n = 0; n < count; n++) begin
      // alternate stretches with and without idling
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      a = angles_t'({$urandom, $urandom});
      case ($urandom_range(0, 5))
        0: begin
          a.angle_x = 16'($signed($urandom_range(0, 255)) - 128);
          a.angle_y = 16'($signed($urandom_range(0, 255)) - 128);
          a.angle_z = 16'($signed($urandom_range(0, 255)) - 128);
        end
        1: begin
          case ($urandom_range(0, 2))
            0: begin a.angle_y = '0; a.angle_z = '0; end
            1: begin a.angle_x = '0; a.angle_z = '0; end
            default: begin a.angle_x = '0; a.angle_y = '0; end
          endcase
        end
        2: begin
          a.angle_x = 16'({$urandom_range(0, 7), 13'h0} + $urandom_range(0, 6) - 3);
          a.angle_z = 16'({$urandom_range(0, 7), 13'h0} + $urandom_range(0, 6) - 3);
        end
        default: ;
      endcase
      send_angles(a);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    error_count   = 0;
    sent_count    = 0;
    checked_count = 0;
    idle_cycles   = 0;
    no_gaps       = 1'b0;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(850);
    in_ch.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending_matrices.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);

    $display("sent %0d angle items, checked %0d matrix items", sent_count, checked_count);
    $display("covered field extremes, quadrant edges, single-axis and planar poses");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/erm_pkg.sv
rtl/erm_if.sv
rtl/erm_sincos.sv
rtl/euler_rotation_matrix.sv
tb/testbench.sv
